/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/utf8d_pkg.sv */
`default_nettype none

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // one byte yields at most two results (broken sequence plus new lead or truncation)
  localparam int MAX_RESULTS = 2;
  localparam int SLOT_W      = $clog2(MAX_RESULTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] ASCII_END = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_END  = 8'hF5;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] LIMIT_2B = 21'h0007FF;
  localparam logic [CP_W-1:0] LIMIT_3B = 21'h00FFFF;

  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_error;
  } utf8d_result_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]                    count;
    utf8d_result_t [MAX_RESULTS-1:0]     res;
  } utf8d_bundle_t;

  typedef struct packed {
    logic          push;
    utf8d_bundle_t data;
  } utf8d_q_wr_t;

  typedef struct packed {
    logic          valid;
    utf8d_bundle_t data;
  } utf8d_q_rd_t;

endpackage

`default_nettype wire

/* rtl/core/utf8d_if.sv */
`default_nettype none

interface utf8d_in_if import utf8d_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_of_buffer;

  modport source (output valid, output byte_value, output end_of_buffer, input ready);
  modport sink   (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

interface utf8d_out_if import utf8d_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_error;
  logic            last_of_run;

  modport source (output valid, output code_point, output is_error, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input is_error, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/utf8d_front.sv */
`default_nettype none

module utf8d_front import utf8d_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_eob,
  output logic                   in_ready,
  output utf8d_q_wr_t            q_wr,
  input  wire logic              q_full
);

  logic            skip_r, skip_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic [2:0]      len_r, len_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;

  logic          in_fire;
  logic          is_start;
  logic          is_cont;
  logic          lead_go;
  utf8d_bundle_t bnd;

  function automatic utf8d_bundle_t push_result(utf8d_bundle_t b, logic [CP_W-1:0] cp,
                                                logic err);
    utf8d_bundle_t r;
    r = b;
    r.res[b.count[SLOT_W-1:0]].code_point = cp;
    r.res[b.count[SLOT_W-1:0]].is_error   = err;
    r.count = b.count + CNT_W'(1);
    return r;
  endfunction

  function automatic logic value_ok(logic [CP_W-1:0] v, logic [2:0] len);
    logic ok;
    if (v >= SURR_LO && v <= SURR_HI) begin
      ok = 1'b0;
    end else if (v > MAX_CP) begin
      ok = 1'b0;
    end else if (v <= LIMIT_2B) begin
      ok = (len == SEQ_LEN_2);
    end else if (v <= LIMIT_3B) begin
      ok = (len == SEQ_LEN_3);
    end else begin
      ok = (len == SEQ_LEN_4);
    end
    return ok;
  endfunction

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  assign is_start = (in_byte < ASCII_END) || (in_byte >= LEAD_MIN && in_byte < LEAD_END);
  assign is_cont  = (in_byte[7:6] == 2'b10);

  always_comb begin
    bnd      = '0;
    skip_nxt = skip_r;
    rem_nxt  = rem_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    lead_go  = 1'b0;

    if (skip_r) begin
      if (is_start) begin
        skip_nxt = 1'b0;
        lead_go  = 1'b1;
      end
    end else if (rem_r != 2'd0) begin
      if (is_cont) begin
        acc_nxt = {acc_r[CP_W-7:0], in_byte[5:0] & CONT_MASK[5:0]};
        rem_nxt = rem_r - 2'd1;
        if (rem_nxt == 2'd0) begin
          if (value_ok(acc_nxt, len_r)) begin
            bnd = push_result(bnd, acc_nxt, 1'b0);
          end else begin
            bnd = push_result(bnd, '0, 1'b1);
          end
          len_nxt = '0;
          acc_nxt = '0;
        end
      end else begin
        // broken sequence: report it, then treat this byte as a lead
        bnd     = push_result(bnd, '0, 1'b1);
        rem_nxt = '0;
        len_nxt = '0;
        acc_nxt = '0;
        lead_go = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end

    if (lead_go) begin
      if (in_byte < ASCII_END) begin
        bnd = push_result(bnd, CP_W'(in_byte), 1'b0);
      end else if (!is_start) begin
        bnd      = push_result(bnd, '0, 1'b1);
        skip_nxt = 1'b1;
      end else if (in_byte < LEAD3_MIN) begin
        len_nxt = SEQ_LEN_2;
        acc_nxt = CP_W'(in_byte[4:0]);
        rem_nxt = 2'd1;
      end else if (in_byte < LEAD4_MIN) begin
        len_nxt = SEQ_LEN_3;
        acc_nxt = CP_W'(in_byte[3:0]);
        rem_nxt = 2'd2;
      end else begin
        len_nxt = SEQ_LEN_4;
        acc_nxt = CP_W'(in_byte[2:0]);
        rem_nxt = 2'd3;
      end
    end

    if (in_eob) begin
      if (rem_nxt != 2'd0) begin
        bnd     = push_result(bnd, '0, 1'b1);
        rem_nxt = '0;
        len_nxt = '0;
        acc_nxt = '0;
      end
      skip_nxt = 1'b0;
    end
  end

  assign q_wr.push = in_fire && (bnd.count != '0);
  assign q_wr.data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
      rem_r  <= '0;
      len_r  <= '0;
      acc_r  <= '0;
    end else if (in_fire) begin
      skip_r <= skip_nxt;
      rem_r  <= rem_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8d_queue.sv */
`default_nettype none

module utf8d_queue import utf8d_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire utf8d_q_wr_t  q_wr,
  output logic              q_full,
  output utf8d_q_rd_t       q_rd,
  input  wire logic         q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8d_bundle_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_full     = (count_r == CNT_W'(DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.data  = mem_r[rd_ptr_r];

  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_rd.valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8d_back.sv */
`default_nettype none

module utf8d_back import utf8d_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire utf8d_q_rd_t     q_rd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [CP_W-1:0]      out_code_point,
  output logic                 out_is_error,
  output logic                 out_last_of_run
);

  logic              hold_valid_r;
  utf8d_bundle_t     hold_r;
  logic [SLOT_W-1:0] slot_r;

  logic          is_last;
  logic          out_fire;
  logic          take;
  utf8d_result_t cur;

  assign is_last  = ((CNT_W'(slot_r) + CNT_W'(1)) == hold_r.count);
  assign out_fire = hold_valid_r && out_ready;
  assign take     = q_rd.valid && (!hold_valid_r || (out_fire && is_last));
  assign q_pop    = take;

  assign cur             = hold_r.res[slot_r];
  assign out_valid       = hold_valid_r;
  assign out_code_point  = cur.code_point;
  assign out_is_error    = cur.is_error;
  assign out_last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= q_rd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      slot_r       <= '0;
    end else if (take) begin
      hold_valid_r <= 1'b1;
      slot_r       <= '0;
    end else if (out_fire && is_last) begin
      hold_valid_r <= 1'b0;
    end else if (out_fire) begin
      slot_r <= slot_r + SLOT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8_validating_decoder_core.sv */
// utf8 validating decoder
// in_chan: one transaction per raw text byte, with end_of_buffer marking the
//   last byte of a buffer; an open sequence at that byte is reported truncated
// out_chan: one transaction per result (code point or error); last_of_run
//   flags the final result caused by one input byte, which may cause none,
//   one or two results
// throughput: one byte per cycle into the front decoder while the result
//   queue is not full; the result side moves one result per cycle while
//   out_chan.ready is high, so a byte with two results holds the back end for both
// result path: the edge that takes a byte writes its results into the result
//   queue; the output holding register then loads the bundle and drives
//   out_chan.valid, once the bundle held before it has been sent
// the result queue holds QUEUE_DEPTH bundles; when the receiver stalls the
//   queue fills and in_chan.ready drops, while the held result stays put
// reset (synchronous, active low) clears the decoder state, empties the
//   queue and drops out_chan.valid
`default_nettype none

module utf8_validating_decoder_core import utf8d_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  utf8d_in_if.sink     in_chan,
  utf8d_out_if.source  out_chan
);

  // front to queue and queue to back
  utf8d_q_wr_t q_wr;
  utf8d_q_rd_t q_rd;
  logic        q_full;
  logic        q_pop;

  // front: per-byte classification and sequence state, one byte per cycle while the queue is not full
  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.byte_value),
    .in_eob   (in_chan.end_of_buffer),
    .in_ready (in_chan.ready),
    .q_wr     (q_wr),
    .q_full   (q_full)
  );

  // result bundles waiting for the back end
  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // back: serializes each bundle into single result transactions
  utf8d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_code_point  (out_chan.code_point),
    .out_is_error    (out_chan.is_error),
    .out_last_of_run (out_chan.last_of_run)
  );

endmodule

`default_nettype wire

/* rtl/core/utf8d_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module utf8d_checker import utf8d_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [CP_W-1:0] out_code_point,
  input wire logic            out_is_error,
  input wire logic            out_last_of_run
);

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_code_point) && $stable(out_is_error) && $stable(out_last_of_run))

  // error results carry a zero code point
  `ASSERT_HOLDS(a_err_zero, clk, rst_n, !(out_valid && out_is_error) || (out_code_point == '0))

  // good results are scalar values only
  `ASSERT_HOLDS(a_scalar, clk, rst_n, !(out_valid && !out_is_error) || ((out_code_point <= MAX_CP) && !((out_code_point >= SURR_LO) && (out_code_point <= SURR_HI))))

endmodule

bind utf8_validating_decoder_core utf8d_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_code_point  (out_chan.code_point),
  .out_is_error    (out_chan.is_error),
  .out_last_of_run (out_chan.last_of_run)
);

`default_nettype wire
